/* rtl/ptzcf_pkg.sv */
// types, constants and command tables shared by the ptz command framer
`timescale 1ns / 1ps

package ptzcf_pkg;

    localparam logic [7:0] D_START    = 8'hFF;
    localparam logic [7:0] P_START    = 8'hA0;
    localparam logic [7:0] P_END      = 8'hAF;
    localparam logic [7:0] PRESET_95  = 8'd95;
    localparam logic [7:0] SCAN_START = 8'h96;
    localparam logic [7:0] SCAN_STOP  = 8'h99;

    localparam logic PROTO_D = 1'b0;
    localparam logic PROTO_P = 1'b1;

    // byte positions within a frame
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_ADDR  = 3'd1;
    localparam logic [2:0] POS_CMD1  = 3'd2;
    localparam logic [2:0] POS_CMD2  = 3'd3;
    localparam logic [2:0] POS_CMD3  = 3'd4;
    localparam logic [2:0] POS_CMD4  = 3'd5;
    localparam logic [2:0] POS_SIX   = 3'd6;
    localparam logic [2:0] POS_SEVEN = 3'd7;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic           valid;
        logic [3:0][7:0] cmd;
    } entry_t;

    typedef struct packed {
        logic            proto;
        logic            invalid;
        logic [7:0]      addr;
        logic [3:0][7:0] cmd;
        logic [7:0]      check;
    } desc_t;

    function automatic entry_t mk(input logic v, input byte_t c1, input byte_t c2,
                                  input byte_t c3, input byte_t c4);
        entry_t e;
        e.valid = v;
        e.cmd   = {c4, c3, c2, c1};
        return e;
    endfunction

    function automatic entry_t d_lookup(input logic [4:0] op);
        entry_t e;
        unique case (op)
            5'd0:    e = mk(1'b1, 8'h00, 8'h08, 8'h00, 8'hFF);
            5'd1:    e = mk(1'b1, 8'h00, 8'h10, 8'h00, 8'hFF);
            5'd2:    e = mk(1'b1, 8'h00, 8'h04, 8'hFF, 8'h00);
            5'd3:    e = mk(1'b1, 8'h00, 8'h02, 8'hFF, 8'h00);
            5'd4:    e = mk(1'b1, 8'h00, 8'h20, 8'h00, 8'h00);
            5'd5:    e = mk(1'b1, 8'h00, 8'h40, 8'h00, 8'h00);
            5'd6:    e = mk(1'b1, 8'h00, 8'h80, 8'h00, 8'h00);
            5'd7:    e = mk(1'b1, 8'h01, 8'h00, 8'h00, 8'h00);
            5'd8:    e = mk(1'b1, 8'h02, 8'h00, 8'h00, 8'h00);
            5'd9:    e = mk(1'b1, 8'h04, 8'h00, 8'h00, 8'h00);
            5'd10:   e = mk(1'b1, 8'h00, 8'h0B, 8'h00, 8'h01);
            5'd11:   e = mk(1'b1, 8'h00, 8'h09, 8'h00, 8'h01);
            5'd12:   e = mk(1'b1, 8'h00, 8'h07, 8'h00, 8'h01);
            5'd13:   e = mk(1'b1, 8'h00, 8'h03, 8'h00, 8'h01);
            5'd14:   e = mk(1'b1, 8'h00, 8'h05, 8'h00, 8'h01);
            5'd15:   e = mk(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
            5'd18:   e = mk(1'b1, 8'h00, 8'h07, 8'h00, PRESET_95);
            5'd19:   e = mk(1'b1, 8'h00, 8'h03, 8'h00, PRESET_95);
            5'd20:   e = mk(1'b1, 8'h00, 8'h05, 8'h00, PRESET_95);
            default: e = mk(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        endcase
        return e;
    endfunction

    function automatic entry_t p_lookup(input logic [4:0] op);
        entry_t e;
        unique case (op)
            5'd0:    e = mk(1'b1, 8'h00, 8'h08, 8'h00, 8'h30);
            5'd1:    e = mk(1'b1, 8'h00, 8'h10, 8'h00, 8'h30);
            5'd2:    e = mk(1'b1, 8'h00, 8'h04, 8'h10, 8'h30);
            5'd3:    e = mk(1'b1, 8'h00, 8'h02, 8'h10, 8'h30);
            5'd4:    e = mk(1'b1, 8'h00, 8'h40, 8'h00, 8'h00);
            5'd5:    e = mk(1'b1, 8'h00, 8'h20, 8'h00, 8'h00);
            5'd6:    e = mk(1'b1, 8'h02, 8'h00, 8'h00, 8'h00);
            5'd7:    e = mk(1'b1, 8'h01, 8'h00, 8'h00, 8'h00);
            5'd8:    e = mk(1'b1, 8'h08, 8'h00, 8'h00, 8'h00);
            5'd9:    e = mk(1'b1, 8'h04, 8'h00, 8'h00, 8'h00);
            5'd12:   e = mk(1'b1, 8'h00, 8'h07, 8'h00, 8'h01);
            5'd13:   e = mk(1'b1, 8'h00, 8'h03, 8'h00, 8'h01);
            5'd14:   e = mk(1'b1, 8'h00, 8'h05, 8'h00, 8'h01);
            5'd15:   e = mk(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
            5'd16:   e = mk(1'b1, 8'h00, SCAN_START, 8'h00, 8'h20);
            5'd17:   e = mk(1'b1, 8'h00, SCAN_STOP, 8'h00, 8'h20);
            5'd18:   e = mk(1'b1, 8'h00, 8'h07, 8'h00, PRESET_95);
            5'd19:   e = mk(1'b1, 8'h00, 8'h03, 8'h00, PRESET_95);
            5'd20:   e = mk(1'b1, 8'h00, 8'h05, 8'h00, PRESET_95);
            default: e = mk(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        endcase
        return e;
    endfunction

endpackage

/* rtl/ptz_camera_command_framer.sv */
// ptz camera command framer top level
`timescale 1ns / 1ps

// Pelco-D / Pelco-P command frame encoder.
// Input queue side: camera_address and opcode are taken at a clock edge with
// push high and full low. Result queue side: while empty is low, frame_byte,
// last_byte and invalid_command show the oldest byte; pop high takes it.
// protocol_select_we writes protocol_select_wdata (0 Pelco-D, 1 Pelco-P);
// the protocol in force when an item is taken decides its framing.
// A Pelco-D command gives 7 bytes, a Pelco-P command 8 bytes, both ending
// with last_byte set. An unknown command gives one byte of zero with
// last_byte and invalid_command set.
// An item passes through the lookup register, the descriptor queue and the
// serialiser in that order.
// The result side gives one byte per cycle while pop is held high; the
// byte-wide serialiser sets the item rate, and the next frame starts in
// the cycle after the last byte of a frame is taken, if the descriptor
// queue holds it.
// When pop is held low the serialiser stops, the descriptor queue fills and
// full rises; items already taken are kept in order.
// Reset clears all items in flight and sets the protocol to Pelco-D.

module ptz_camera_command_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       protocol_select_we,
    input  logic       protocol_select_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] camera_address,
    input  logic [4:0] opcode,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] frame_byte,
    output logic       last_byte,
    output logic       invalid_command
);
    import ptzcf_pkg::*;

    logic  proto_reg;
    logic  proto_next;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    desc_t q_wdata;
    desc_t q_rdata;

    assign proto_next = protocol_select_we ? protocol_select_wdata : proto_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg <= PROTO_D;
        end
        else
        begin
            proto_reg <= proto_next;
        end
    end

    ptzcf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .camera_address (camera_address),
        .opcode         (opcode),
        .proto          (proto_reg),
        .q_push         (q_push),
        .q_full         (q_full),
        .q_data         (q_wdata)
    );

    ptzcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    ptzcf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte),
        .invalid_command (invalid_command)
    );

endmodule

/* rtl/ptzcf_front.sv */
// front stage: command lookup, checksum and frame descriptor register
`timescale 1ns / 1ps

module ptzcf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         camera_address,
    input  logic [4:0]         opcode,
    input  logic               proto,
    output logic               q_push,
    input  logic               q_full,
    output ptzcf_pkg::desc_t   q_data
);
    import ptzcf_pkg::*;

    entry_t     ent;
    desc_t      desc_next;
    desc_t      desc_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       accept;
    logic [7:0] sum;
    logic [7:0] xsum;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = desc_reg;

    always_comb
    begin
        ent  = (proto == PROTO_P) ? p_lookup(opcode) : d_lookup(opcode);
        sum  = camera_address + ent.cmd[0] + ent.cmd[1] + ent.cmd[2] + ent.cmd[3];
        xsum = P_START ^ camera_address ^ ent.cmd[0] ^ ent.cmd[1] ^ ent.cmd[2]
               ^ ent.cmd[3] ^ P_END;
        desc_next.proto   = proto;
        desc_next.invalid = !ent.valid;
        desc_next.addr    = camera_address;
        desc_next.cmd     = ent.cmd;
        desc_next.check   = (proto == PROTO_P) ? xsum : sum;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

    // holding an item the queue cannot take keeps it offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && q_full) |=> valid_reg)
        else $error("front item dropped while queue full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && q_full) |=> $stable(desc_reg))
        else $error("front descriptor changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted item not held");

endmodule

/* rtl/ptzcf_queue.sv */
// short descriptor queue between front and back stages
`timescale 1ns / 1ps

module ptzcf_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ptzcf_pkg::desc_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output ptzcf_pkg::desc_t rdata
);
    import ptzcf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count not incremented on push");

endmodule

/* rtl/ptzcf_back.sv */
// back stage: serialises one frame descriptor into bytes
`timescale 1ns / 1ps

module ptzcf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  ptzcf_pkg::desc_t q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       frame_byte,
    output logic             last_byte,
    output logic             invalid_command
);
    import ptzcf_pkg::*;

    desc_t      cur_reg;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] last_idx;
    logic       is_last;
    logic       advance;
    logic       load;

    assign last_idx = (cur_reg.proto == PROTO_P) ? POS_SEVEN : POS_SIX;
    assign is_last  = cur_reg.invalid || (idx_reg == last_idx);
    assign advance  = pop && cur_valid_reg;
    assign load     = !cur_valid_reg || (advance && is_last);
    assign q_pop    = load && !q_empty;

    assign empty           = !cur_valid_reg;
    assign last_byte       = is_last;
    assign invalid_command = cur_reg.invalid;

    always_comb
    begin
        if (cur_reg.invalid)
        begin
            frame_byte = 8'h00;
        end
        else
        begin
            unique case (idx_reg)
                POS_START: frame_byte = (cur_reg.proto == PROTO_P) ? P_START : D_START;
                POS_ADDR:  frame_byte = cur_reg.addr;
                POS_CMD1:  frame_byte = cur_reg.cmd[0];
                POS_CMD2:  frame_byte = cur_reg.cmd[1];
                POS_CMD3:  frame_byte = cur_reg.cmd[2];
                POS_CMD4:  frame_byte = cur_reg.cmd[3];
                POS_SIX:   frame_byte = (cur_reg.proto == PROTO_P) ? P_END : cur_reg.check;
                POS_SEVEN: frame_byte = cur_reg.check;
                default:   frame_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = !q_empty;
            idx_next       = POS_START;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= POS_START;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && cur_reg.invalid) |-> (idx_reg == POS_START))
        else $error("invalid item spans more than one byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && cur_reg.proto == PROTO_D) |-> (idx_reg != POS_SEVEN))
        else $error("pelco-d frame ran past seven bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !pop) |=> ($stable(idx_reg) && cur_valid_reg))
        else $error("byte index moved while stalled");

endmodule

/* sim/ptz_camera_command_framer_tb.sv */
// testbench for the ptz camera command framer: random and directed commands checked per byte
`timescale 1ns / 1ps

module ptz_camera_command_framer_tb;

    import ptzcf_pkg::*;

    localparam int IDLE_PCT   = 21;
    localparam int MAX_CYCLES = 200000;
    localparam int SHOW_MAX   = 10;

    typedef enum logic [4:0] {
        OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT, OP_ZOOM_SHORT, OP_ZOOM_LONG,
        OP_FOCUS_NEAR, OP_FOCUS_FAR, OP_IRIS_NARROW, OP_IRIS_WIDE,
        OP_LIGHT_OFF, OP_LIGHT_ON, OP_GOTO_P1, OP_SET_P1, OP_DEL_P1, OP_STOP,
        OP_SCAN_START, OP_SCAN_STOP, OP_GOTO_P95, OP_SET_P95, OP_DEL_P95
    } camera_op_e;

    localparam logic [4:0] OP_FIRST_UNDEF = 5'd21;
    localparam logic [4:0] OP_TOP         = 5'd31;

    typedef struct packed {
        logic [7:0] addr;
        logic [4:0] op;
    } command_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [7:0] c4;
    } cmd_bytes_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       bad;
    } frame_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       protocol_select_we = 1'b0;
    logic       protocol_select_wdata = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] camera_address = 8'h00;
    logic [4:0] opcode = 5'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       invalid_command;

    command_t   pending_cmds[$];
    frame_out_t expected_bytes[$];
    command_t   next_cmd;
    frame_out_t want;

    logic proto_now = PROTO_D;
    logic took_item = 1'b0;
    logic steady = 1'b0;
    int   cmds_queued = 0;
    int   cmds_taken = 0;
    int   bytes_checked = 0;
    int   d_frames = 0;
    int   p_frames = 0;
    int   rejected = 0;
    int   proto_writes = 0;
    int   errors = 0;
    int   cycle_count = 0;

    ptz_camera_command_framer u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .protocol_select_we    (protocol_select_we),
        .protocol_select_wdata (protocol_select_wdata),
        .push                  (push),
        .full                  (full),
        .camera_address        (camera_address),
        .opcode                (opcode),
        .empty                 (empty),
        .pop                   (pop),
        .frame_byte            (frame_byte),
        .last_byte             (last_byte),
        .invalid_command       (invalid_command)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cmd_bytes_t command_lookup(input logic proto, input logic [4:0] op);
        cmd_bytes_t e;
        e = '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00};
        case (op)
            OP_GOTO_P1:  e = '{1'b1, 8'h00, 8'h07, 8'h00, 8'h01};
            OP_SET_P1:   e = '{1'b1, 8'h00, 8'h03, 8'h00, 8'h01};
            OP_DEL_P1:   e = '{1'b1, 8'h00, 8'h05, 8'h00, 8'h01};
            OP_STOP:     e = '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00};
            OP_GOTO_P95: e = '{1'b1, 8'h00, 8'h07, 8'h00, PRESET_95};
            OP_SET_P95:  e = '{1'b1, 8'h00, 8'h03, 8'h00, PRESET_95};
            OP_DEL_P95:  e = '{1'b1, 8'h00, 8'h05, 8'h00, PRESET_95};
            default:
            begin
                if (proto == PROTO_D)
                begin
                    case (op)
                        OP_UP:          e = '{1'b1, 8'h00, 8'h08, 8'h00, 8'hFF};
                        OP_DOWN:        e = '{1'b1, 8'h00, 8'h10, 8'h00, 8'hFF};
                        OP_LEFT:        e = '{1'b1, 8'h00, 8'h04, 8'hFF, 8'h00};
                        OP_RIGHT:       e = '{1'b1, 8'h00, 8'h02, 8'hFF, 8'h00};
                        OP_ZOOM_SHORT:  e = '{1'b1, 8'h00, 8'h20, 8'h00, 8'h00};
                        OP_ZOOM_LONG:   e = '{1'b1, 8'h00, 8'h40, 8'h00, 8'h00};
                        OP_FOCUS_NEAR:  e = '{1'b1, 8'h00, 8'h80, 8'h00, 8'h00};
                        OP_FOCUS_FAR:   e = '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00};
                        OP_IRIS_NARROW: e = '{1'b1, 8'h02, 8'h00, 8'h00, 8'h00};
                        OP_IRIS_WIDE:   e = '{1'b1, 8'h04, 8'h00, 8'h00, 8'h00};
                        OP_LIGHT_OFF:   e = '{1'b1, 8'h00, 8'h0B, 8'h00, 8'h01};
                        OP_LIGHT_ON:    e = '{1'b1, 8'h00, 8'h09, 8'h00, 8'h01};
                        default:        e.ok = 1'b0;
                    endcase
                end
                else
                begin
                    case (op)
                        OP_UP:          e = '{1'b1, 8'h00, 8'h08, 8'h00, 8'h30};
                        OP_DOWN:        e = '{1'b1, 8'h00, 8'h10, 8'h00, 8'h30};
                        OP_LEFT:        e = '{1'b1, 8'h00, 8'h04, 8'h10, 8'h30};
                        OP_RIGHT:       e = '{1'b1, 8'h00, 8'h02, 8'h10, 8'h30};
                        OP_ZOOM_SHORT:  e = '{1'b1, 8'h00, 8'h40, 8'h00, 8'h00};
                        OP_ZOOM_LONG:   e = '{1'b1, 8'h00, 8'h20, 8'h00, 8'h00};
                        OP_FOCUS_NEAR:  e = '{1'b1, 8'h02, 8'h00, 8'h00, 8'h00};
                        OP_FOCUS_FAR:   e = '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00};
                        OP_IRIS_NARROW: e = '{1'b1, 8'h08, 8'h00, 8'h00, 8'h00};
                        OP_IRIS_WIDE:   e = '{1'b1, 8'h04, 8'h00, 8'h00, 8'h00};
                        OP_SCAN_START:  e = '{1'b1, 8'h00, SCAN_START, 8'h00, 8'h20};
                        OP_SCAN_STOP:   e = '{1'b1, 8'h00, SCAN_STOP, 8'h00, 8'h20};
                        default:        e.ok = 1'b0;
                    endcase
                end
            end
        endcase
        return e;
    endfunction

    // builds the byte sequence one command should produce
    task automatic predict_frame(input logic proto, input logic [7:0] addr,
                                 input logic [4:0] op);
        cmd_bytes_t e;
        logic [7:0] seq [0:7];
        logic [7:0] check;
        int         n;
        e = command_lookup(proto, op);
        if (!e.ok)
        begin
            expected_bytes.push_back('{8'h00, 1'b1, 1'b1});
            rejected++;
            return;
        end
        seq[1] = addr;
        seq[2] = e.c1;
        seq[3] = e.c2;
        seq[4] = e.c3;
        seq[5] = e.c4;
        if (proto == PROTO_D)
        begin
            seq[0] = D_START;
            check  = addr + e.c1 + e.c2 + e.c3 + e.c4;
            seq[6] = check;
            n = 7;
            d_frames++;
        end
        else
        begin
            seq[0] = P_START;
            seq[6] = P_END;
            check  = P_START ^ addr ^ e.c1 ^ e.c2 ^ e.c3 ^ e.c4 ^ P_END;
            seq[7] = check;
            n = 8;
            p_frames++;
        end
        for (int k = 0; k < n; k++)
            expected_bytes.push_back('{seq[k], k == n - 1, 1'b0});
    endtask

    task automatic queue_cmd(input logic [7:0] addr, input logic [4:0] op);
        pending_cmds.push_back('{addr, op});
        cmds_queued++;
    endtask

    task automatic queue_random_cmd();
        logic [7:0] addr;
        logic [4:0] op;
        case ($urandom_range(0, 9))
            0:       addr = 8'h00;
            1:       addr = 8'hFF;
            default: addr = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < 15)
            op = 5'($urandom_range(OP_FIRST_UNDEF, OP_TOP));
        else
            op = 5'($urandom_range(OP_UP, OP_DEL_P95));
        queue_cmd(addr, op);
    endtask

    task automatic wait_drained();
        while (cmds_taken != cmds_queued || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_protocol(input logic proto);
        protocol_select_we    <= 1'b1;
        protocol_select_wdata <= proto;
        @(negedge clk);
        protocol_select_we    <= 1'b0;
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || took_item)
        begin
            if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_cmd = pending_cmds.pop_front();
                push           <= 1'b1;
                camera_address <= next_cmd.addr;
                opcode         <= next_cmd.op;
            end
            else
                push <= 1'b0;
        end
    end

    // byte sink
    always @(negedge clk)
    begin
        pop <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("** ptz_camera_command_framer: FAILED **");
            $finish;
        end
        if (rst_n)
        begin
            if (protocol_select_we)
            begin
                proto_now = protocol_select_wdata;
                proto_writes++;
            end
            took_item <= push && !full;
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("unexpected byte %02h last %0b invalid %0b",
                                 frame_byte, last_byte, invalid_command);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (frame_byte !== want.value || last_byte !== want.last ||
                        invalid_command !== want.bad)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display("byte %0d: want %02h/%0b/%0b got %02h/%0b/%0b",
                                     bytes_checked, want.value, want.last, want.bad,
                                     frame_byte, last_byte, invalid_command);
                    end
                end
            end
            if (push && !full)
            begin
                predict_frame(proto_now, camera_address, opcode);
                cmds_taken++;
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // pelco-d after reset: every command code, address extremes, undefined codes
        for (int op = OP_UP; op <= OP_DEL_P95; op++)
            queue_cmd((op % 2) ? 8'hFF : 8'h00, 5'(op));
        queue_cmd(8'hFF, OP_FIRST_UNDEF);
        queue_cmd(8'h00, OP_TOP);
        wait_drained();

        // pelco-p: codes that differ from pelco-d, the last table entry and an undefined code
        write_protocol(PROTO_P);
        queue_cmd(8'h00, OP_LIGHT_OFF);
        queue_cmd(8'hFF, OP_LIGHT_ON);
        queue_cmd(8'hFF, OP_SCAN_START);
        queue_cmd(8'h00, OP_SCAN_STOP);
        queue_cmd(8'hFF, OP_DEL_P95);
        queue_cmd(8'h5A, OP_TOP);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_protocol((ph % 2) ? PROTO_P : PROTO_D);
            steady = (ph == 3);
            repeat (75) queue_random_cmd();
            wait_drained();
        end
        steady = 1'b0;

        repeat (20) @(negedge clk);
        if (expected_bytes.size() != 0)
        begin
            errors++;
            $display("%0d expected bytes never arrived", expected_bytes.size());
        end
        $display("covered %0d commands: %0d pelco-d frames, %0d pelco-p frames, %0d rejected",
                 cmds_taken, d_frames, p_frames, rejected);
        $display("%0d bytes checked over %0d protocol writes, %0d errors",
                 bytes_checked, proto_writes, errors);
        if (errors == 0)
            $display("** ptz_camera_command_framer: PASSED **");
        else
            $display("** ptz_camera_command_framer: FAILED **");
        $finish;
    end

endmodule

/* ptz_camera_command_framer.f */
rtl/ptzcf_pkg.sv
rtl/ptzcf_front.sv
rtl/ptzcf_queue.sv
rtl/ptzcf_back.sv
rtl/ptz_camera_command_framer.sv
sim/ptz_camera_command_framer_tb.sv
